[src/pmlf_pkg.sv]
package pmlf_pkg;

    // Output fixed point: results carry OUT_FRAC fraction bits, the power factor PF_FRAC
    localparam int OUT_FRAC   = 16;
    localparam int SCALE_FRAC = 40;
    localparam int SCALE_SH   = SCALE_FRAC - OUT_FRAC;
    localparam int PF_FRAC    = 15;

    // Field widths
    localparam int RAW_W    = 24;
    localparam int PHASE_W  = 2;
    localparam int PERIOD_W = 16;
    localparam int VAL_W    = 32;
    localparam int PM_W     = 35;
    localparam int PF_W     = 16;
    localparam int FREQ_W   = 24;
    localparam int FREQ_FRAC = 16;
    localparam int BAND_W   = 8;

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 60;
    localparam int PS_W   = 36;

    // Rounding offsets
    localparam logic [PROD_W:0] RND_SCALE = (PROD_W + 1)'(1) << (SCALE_SH - 1);
    localparam logic [PROD_W:0] RND_OUT   = (PROD_W + 1)'(1) << (OUT_FRAC - 1);
    localparam logic [ACC_W:0]  RND_ACC   = (ACC_W + 1)'(1) << (SCALE_SH - 1);

    // Active power magnitude limits
    localparam logic [PM_W-1:0] PM_POS_MAX = (PM_W)'(35'h3_FFFF_FFFF);
    localparam logic [PM_W-1:0] PM_NEG_MAX = (PM_W)'(35'h4_0000_0000);

    // Power factor limits
    localparam logic [PF_W-1:0] PF_POS_SAT = 16'h7FFF;
    localparam logic [PF_W-1:0] PF_NEG_SAT = 16'h8000;

    // Shared divider
    localparam int DIV_W    = 50;
    localparam int QUO_W    = 28;
    localparam int STEP_W   = $clog2(QUO_W + 1);
    localparam int PF_STEPS = PF_FRAC + 1;

    // Line frequency
    localparam logic [DIV_W-1:0]    FREQ_NUM   = DIV_W'(64'd256000 << FREQ_FRAC);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'd65000;
    localparam logic [FREQ_W-1:0]   FREQ_RESET = 24'd3932160;
    localparam int AVG_SUM_W = FREQ_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX    = 3'd4;

    localparam logic [VAL_W-1:0]  VOLT_SCALE_RST  = 32'd93185037;
    localparam logic [VAL_W-1:0]  CURR_SCALE_RST  = 32'd927217;
    localparam logic [PS_W-1:0]   POWER_SCALE_RST = 36'd26262663000;
    localparam logic [BAND_W-1:0] FREQ_MIN_RST    = 8'd45;
    localparam logic [BAND_W-1:0] FREQ_MAX_RST    = 8'd65;

    // Divider command
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

endpackage

[src/pmlf_in_if.sv]
interface pmlf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [pmlf_pkg::PHASE_W-1:0]           phase;
    logic [pmlf_pkg::RAW_W-1:0]             vrms_raw;
    logic [pmlf_pkg::RAW_W-1:0]             irms_raw;
    logic signed [pmlf_pkg::RAW_W-1:0]      watt_raw;
    logic [pmlf_pkg::PERIOD_W-1:0]          period_raw;

    modport source (
        output valid, kind, phase, vrms_raw, irms_raw, watt_raw, period_raw,
        input  ready
    );
    modport sink (
        input  valid, kind, phase, vrms_raw, irms_raw, watt_raw, period_raw,
        output ready
    );
endinterface

[src/pmlf_out_if.sv]
interface pmlf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   result_kind;
    logic [pmlf_pkg::PHASE_W-1:0]           phase_out;
    logic [pmlf_pkg::VAL_W-1:0]             voltage;
    logic [pmlf_pkg::VAL_W-1:0]             current;
    logic signed [pmlf_pkg::PM_W-1:0]       active_power;
    logic [pmlf_pkg::VAL_W-1:0]             apparent_power;
    logic signed [pmlf_pkg::PF_W-1:0]       power_factor;
    logic [pmlf_pkg::FREQ_W-1:0]            line_freq;

    modport source (
        output valid, result_kind, phase_out, voltage, current, active_power,
               apparent_power, power_factor, line_freq,
        input  ready
    );
    modport sink (
        input  valid, result_kind, phase_out, voltage, current, active_power,
               apparent_power, power_factor, line_freq,
        output ready
    );
endinterface

[src/pmlf_mul.sv]
module pmlf_mul (
    input  logic                            i_clk,
    input  logic [pmlf_pkg::MUL_W-1:0]      i_a,
    input  logic [pmlf_pkg::MUL_W-1:0]      i_b,
    output logic [pmlf_pkg::PROD_W-1:0]     o_p
);

    logic [pmlf_pkg::PROD_W-1:0] r_p;

    // Unsigned multiply, product registered
    always_ff @(posedge i_clk) begin
        r_p <= pmlf_pkg::PROD_W'(i_a) * pmlf_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[src/pmlf_div.sv]
module pmlf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmlf_pkg::t_div_ctl              i_ctl,
    input  logic [pmlf_pkg::DIV_W-1:0]      i_num,
    input  logic [pmlf_pkg::DIV_W-1:0]      i_den,
    output logic                            o_busy,
    output logic [pmlf_pkg::QUO_W-1:0]      o_quo
);

    logic [pmlf_pkg::STEP_W-1:0] r_cnt;
    logic [pmlf_pkg::DIV_W-1:0]  r_rem;
    logic [pmlf_pkg::DIV_W-1:0]  r_den;
    logic [pmlf_pkg::QUO_W-1:0]  r_quo;
    logic [pmlf_pkg::DIV_W:0]    diff;
    logic                        ge;

    // Trial subtract of the shifted divisor
    assign diff = {1'b0, r_rem} - {1'b0, r_den};
    assign ge   = !diff[pmlf_pkg::DIV_W];

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= i_ctl.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[pmlf_pkg::DIV_W-1:0] : r_rem;
            r_quo <= {r_quo[pmlf_pkg::QUO_W-2:0], ge};
            r_den <= r_den >> 1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

[src/power_metrics_and_line_frequency.sv]
// A phase item skips the division when apparent power is zero, and a period item
//   skips it when the period is out of range.
// Throughput: one item at a time, next transfer in the cycle after the result is
//   loaded; set by the shared 32x32 multiplier (five products) and the one-bit-
//   per-cycle divider (16 steps for power factor, 28 for frequency).
// Reset (synchronous, active low): idle, no result, defaults, average 60 Hz.
module power_metrics_and_line_frequency (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pmlf_in_if.sink                             i_in,
    pmlf_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [pmlf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pmlf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV,
        S_MI,
        S_MP0,
        S_MP1,
        S_MS,
        S_PRND,
        S_DIVST,
        S_FST,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [pmlf_pkg::VAL_W-1:0]  r_volt_scale;
    logic [pmlf_pkg::VAL_W-1:0]  r_curr_scale;
    logic [pmlf_pkg::PS_W-1:0]   r_power_scale;
    logic [pmlf_pkg::BAND_W-1:0] r_freq_min;
    logic [pmlf_pkg::BAND_W-1:0] r_freq_max;

    // Latched item
    logic                           r_kind;
    logic [pmlf_pkg::PHASE_W-1:0]   r_phase;
    logic [pmlf_pkg::RAW_W-1:0]     r_vrms;
    logic [pmlf_pkg::RAW_W-1:0]     r_irms;
    logic [pmlf_pkg::RAW_W-1:0]     r_wm;
    logic                           r_neg;
    logic [pmlf_pkg::PERIOD_W-1:0]  r_period;

    // Working values
    logic [pmlf_pkg::VAL_W-1:0]     r_v;
    logic [pmlf_pkg::VAL_W-1:0]     r_i;
    logic [pmlf_pkg::VAL_W-1:0]     r_s;
    logic [pmlf_pkg::ACC_W-1:0]     r_acc;
    logic [pmlf_pkg::PM_W-1:0]      r_pm;
    logic [pmlf_pkg::PF_W-1:0]      r_pf;
    logic [pmlf_pkg::FREQ_W-1:0]    r_avg;
    logic                           r_seeded;

    // Output register
    logic                           r_o_valid;
    logic                           r_o_kind;
    logic [pmlf_pkg::PHASE_W-1:0]   r_o_phase;
    logic [pmlf_pkg::VAL_W-1:0]     r_o_volt;
    logic [pmlf_pkg::VAL_W-1:0]     r_o_curr;
    logic [pmlf_pkg::PM_W-1:0]      r_o_ap;
    logic [pmlf_pkg::VAL_W-1:0]     r_o_s;
    logic [pmlf_pkg::PF_W-1:0]      r_o_pf;
    logic [pmlf_pkg::FREQ_W-1:0]    r_o_freq;

    // Shared units
    logic [pmlf_pkg::MUL_W-1:0]     mul_a;
    logic [pmlf_pkg::MUL_W-1:0]     mul_b;
    logic [pmlf_pkg::PROD_W-1:0]    mul_p;
    pmlf_pkg::t_div_ctl             div_ctl;
    logic [pmlf_pkg::DIV_W-1:0]     div_num;
    logic [pmlf_pkg::DIV_W-1:0]     div_den;
    logic                           div_busy;
    logic [pmlf_pkg::QUO_W-1:0]     div_quo;

    // Rounding and saturation
    logic [pmlf_pkg::PROD_W:0]      sc_sum;
    logic [pmlf_pkg::PROD_W:0]      sc_shr;
    logic [pmlf_pkg::VAL_W-1:0]     sc_sat;
    logic [pmlf_pkg::PROD_W:0]      of_sum;
    logic [pmlf_pkg::PROD_W:0]      of_shr;
    logic [pmlf_pkg::VAL_W-1:0]     of_sat;
    logic [pmlf_pkg::ACC_W:0]       acc_sum;
    logic [pmlf_pkg::ACC_W:0]       acc_shr;
    logic [pmlf_pkg::PM_W-1:0]      pm_lim;
    logic [pmlf_pkg::PM_W-1:0]      pm_sat;

    // Frequency and power factor finish
    logic                           period_ok;
    logic [pmlf_pkg::QUO_W-1:0]     band_lo;
    logic [pmlf_pkg::QUO_W-1:0]     band_hi;
    logic                           in_band;
    logic [pmlf_pkg::AVG_SUM_W-1:0] avg_sum;
    logic                           pf_sat;
    logic [pmlf_pkg::PF_W-1:0]      pf_mag;
    logic [pmlf_pkg::PF_W-1:0]      pf_val;

    logic [pmlf_pkg::RAW_W-1:0]     in_w;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           out_load;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_o_valid && o_out.ready;
    assign out_load = (r_state == S_OUT) && (!r_o_valid || o_out.ready);
    assign in_w     = i_in.watt_raw;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_scale  <= pmlf_pkg::VOLT_SCALE_RST;
            r_curr_scale  <= pmlf_pkg::CURR_SCALE_RST;
            r_power_scale <= pmlf_pkg::POWER_SCALE_RST;
            r_freq_min    <= pmlf_pkg::FREQ_MIN_RST;
            r_freq_max    <= pmlf_pkg::FREQ_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmlf_pkg::CFG_VOLT_SCALE: begin
                    r_volt_scale <= i_cfg_data[pmlf_pkg::VAL_W-1:0];
                end
                pmlf_pkg::CFG_CURR_SCALE: begin
                    r_curr_scale <= i_cfg_data[pmlf_pkg::VAL_W-1:0];
                end
                pmlf_pkg::CFG_POWER_SCALE: begin
                    r_power_scale <= i_cfg_data[pmlf_pkg::PS_W-1:0];
                end
                pmlf_pkg::CFG_FREQ_MIN: begin
                    r_freq_min <= i_cfg_data[pmlf_pkg::BAND_W-1:0];
                end
                pmlf_pkg::CFG_FREQ_MAX: begin
                    r_freq_max <= i_cfg_data[pmlf_pkg::BAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MV: begin
                mul_a = pmlf_pkg::MUL_W'(r_vrms);
                mul_b = r_volt_scale;
            end
            S_MI: begin
                mul_a = pmlf_pkg::MUL_W'(r_irms);
                mul_b = r_curr_scale;
            end
            S_MP0: begin
                mul_a = pmlf_pkg::MUL_W'(r_wm);
                mul_b = r_power_scale[pmlf_pkg::MUL_W-1:0];
            end
            S_MP1: begin
                mul_a = pmlf_pkg::MUL_W'(r_wm);
                mul_b = pmlf_pkg::MUL_W'(r_power_scale[pmlf_pkg::PS_W-1:pmlf_pkg::MUL_W]);
            end
            S_MS: begin
                mul_a = r_v;
                mul_b = r_i;
            end
            default: begin
            end
        endcase
    end

    pmlf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Round and saturate the registered product and the active power accumulator
    always_comb begin
        sc_sum = {1'b0, mul_p} + pmlf_pkg::RND_SCALE;
        sc_shr = sc_sum >> pmlf_pkg::SCALE_SH;
        sc_sat = (|sc_shr[pmlf_pkg::PROD_W:pmlf_pkg::VAL_W]) ? '1
                                                             : sc_shr[pmlf_pkg::VAL_W-1:0];
        of_sum = {1'b0, mul_p} + pmlf_pkg::RND_OUT;
        of_shr = of_sum >> pmlf_pkg::OUT_FRAC;
        of_sat = (|of_shr[pmlf_pkg::PROD_W:pmlf_pkg::VAL_W]) ? '1
                                                             : of_shr[pmlf_pkg::VAL_W-1:0];
        acc_sum = {1'b0, r_acc} + pmlf_pkg::RND_ACC;
        acc_shr = acc_sum >> pmlf_pkg::SCALE_SH;
        pm_lim  = r_neg ? pmlf_pkg::PM_NEG_MAX : pmlf_pkg::PM_POS_MAX;
        pm_sat  = (acc_shr > (pmlf_pkg::ACC_W + 1)'(pm_lim)) ? pm_lim
                                                             : acc_shr[pmlf_pkg::PM_W-1:0];
    end

    // Divider command
    assign period_ok = (r_period >= pmlf_pkg::PERIOD_MIN) &&
                       (r_period <= pmlf_pkg::PERIOD_MAX);

    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.steps = pmlf_pkg::STEP_W'(pmlf_pkg::QUO_W);
        div_num       = pmlf_pkg::FREQ_NUM + pmlf_pkg::DIV_W'(r_period[pmlf_pkg::PERIOD_W-1:1]);
        div_den       = pmlf_pkg::DIV_W'(r_period) << (pmlf_pkg::QUO_W - 1);
        if (r_state == S_DIVST) begin
            div_ctl.start = (r_s != '0);
            div_ctl.steps = pmlf_pkg::STEP_W'(pmlf_pkg::PF_STEPS);
            div_num       = (pmlf_pkg::DIV_W'(r_pm) << pmlf_pkg::PF_FRAC) +
                            pmlf_pkg::DIV_W'(r_s[pmlf_pkg::VAL_W-1:1]);
            div_den       = pmlf_pkg::DIV_W'(r_s) << pmlf_pkg::PF_FRAC;
        end else if (r_state == S_FST) begin
            div_ctl.start = period_ok;
        end
    end

    pmlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Frequency band check and quarter-weight average
    assign band_lo = pmlf_pkg::QUO_W'({r_freq_min, pmlf_pkg::FREQ_FRAC'(0)});
    assign band_hi = pmlf_pkg::QUO_W'({r_freq_max, pmlf_pkg::FREQ_FRAC'(0)});
    assign in_band = (div_quo >= band_lo) && (div_quo <= band_hi);
    assign avg_sum = pmlf_pkg::AVG_SUM_W'(div_quo[pmlf_pkg::FREQ_W-1:0]) +
                     pmlf_pkg::AVG_SUM_W'(r_avg) +
                     (pmlf_pkg::AVG_SUM_W'(r_avg) << 1) +
                     pmlf_pkg::AVG_SUM_W'(2);

    // Power factor from the quotient; top bit flags saturation
    assign pf_sat = div_quo[pmlf_pkg::PF_FRAC];
    assign pf_mag = pmlf_pkg::PF_W'(div_quo[pmlf_pkg::PF_FRAC-1:0]);
    always_comb begin
        if (r_neg) begin
            pf_val = pf_sat ? pmlf_pkg::PF_NEG_SAT : (~pf_mag + 1'b1);
        end else begin
            pf_val = pf_sat ? pmlf_pkg::PF_POS_SAT : pf_mag;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_avg     <= pmlf_pkg::FREQ_RESET;
            r_seeded  <= 1'b0;
        end else begin
            // a new result load takes priority over the draining transfer
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind   <= i_in.kind;
                        r_phase  <= i_in.phase;
                        r_vrms   <= i_in.vrms_raw;
                        r_irms   <= i_in.irms_raw;
                        r_neg    <= in_w[pmlf_pkg::RAW_W-1];
                        r_wm     <= in_w[pmlf_pkg::RAW_W-1] ? (~in_w + 1'b1) : in_w;
                        r_period <= i_in.period_raw;
                        r_state  <= i_in.kind ? S_FST : S_MV;
                    end
                end
                S_MV: begin
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_v     <= sc_sat;
                    r_state <= S_MP0;
                end
                S_MP0: begin
                    r_i     <= sc_sat;
                    r_state <= S_MP1;
                end
                S_MP1: begin
                    r_acc   <= pmlf_pkg::ACC_W'(mul_p);
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_acc   <= r_acc + (pmlf_pkg::ACC_W'(mul_p) << pmlf_pkg::MUL_W);
                    r_state <= S_PRND;
                end
                S_PRND: begin
                    r_s     <= of_sat;
                    r_pm    <= pm_sat;
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    // zero apparent power: no division, factor is zero
                    r_pf    <= '0;
                    r_state <= (r_s != '0) ? S_DIV : S_OUT;
                end
                S_FST: begin
                    r_state <= period_ok ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_kind) begin
                        if (in_band) begin
                            r_seeded <= 1'b1;
                            r_avg    <= r_seeded ? avg_sum[pmlf_pkg::AVG_SUM_W-1:2]
                                                 : div_quo[pmlf_pkg::FREQ_W-1:0];
                        end
                    end else begin
                        r_pf <= pf_val;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_kind  <= r_kind;
                        r_o_freq  <= r_avg;
                        if (r_kind) begin
                            r_o_phase <= '0;
                            r_o_volt  <= '0;
                            r_o_curr  <= '0;
                            r_o_ap    <= '0;
                            r_o_s     <= '0;
                            r_o_pf    <= '0;
                        end else begin
                            r_o_phase <= r_phase;
                            r_o_volt  <= r_v;
                            r_o_curr  <= r_i;
                            r_o_ap    <= r_neg ? (~r_pm + 1'b1) : r_pm;
                            r_o_s     <= r_s;
                            r_o_pf    <= r_pf;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.result_kind    = r_o_kind;
    assign o_out.phase_out      = r_o_phase;
    assign o_out.voltage        = r_o_volt;
    assign o_out.current        = r_o_curr;
    assign o_out.active_power   = $signed(r_o_ap);
    assign o_out.apparent_power = r_o_s;
    assign o_out.power_factor   = $signed(r_o_pf);
    assign o_out.line_freq      = r_o_freq;

endmodule
